// ===== src/srt_pkg.sv =====
// Shared types and constants for the integer array sorter.
// No dependencies; used by srt_cell and integer_array_sorter.
package srt_pkg;

   localparam int MAX_ELEMENTS = 32;
   localparam int COUNT_W      = $clog2(MAX_ELEMENTS + 1);

   typedef struct packed {
      logic signed [31:0] value;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value_res;
      logic               last_res;
      logic               overflowed;
   } rsp_type;

   // One slot of the sorting chain: a held element or an element in flight.
   typedef struct packed {
      logic               vld;
      logic signed [31:0] value;
   } entry_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SETTLE,
      ST_DRAIN
   } state_type;

endpackage

// ===== src/integer_array_sorter.sv =====
// Top level of the integer array sorter: load/settle/drain control around a cell chain.
// Depends on srt_pkg and srt_cell.
//
// Usage: present one signed 32-bit item per cycle with start high while busy is low; the
// item with last set closes the batch. Each item enters cell 0 of a row of MAX_ELEMENTS
// cells the cycle it is taken, so loading runs at one item per cycle. After the closing
// item busy rises while the last insertion wave ripples down the chain (one cell per
// cycle), and stays high while the sorted items leave from cell 0, smallest first, one
// per cycle with rsp_valid high for exactly that cycle. The receiver cannot stall the
// output, so it must take every strobed item. Items beyond MAX_ELEMENTS are dropped and
// every item of that batch carries overflowed; a new batch is taken only once busy falls.
module integer_array_sorter (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  srt_pkg::req_type req_item,
   output logic             rsp_valid,
   output srt_pkg::rsp_type rsp_item
);

   localparam int N = srt_pkg::MAX_ELEMENTS;
   localparam int CW = srt_pkg::COUNT_W;

   srt_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;   // stored items this batch
   logic [CW-1:0]      phase_ff, phase_in;   // settle / drain countdown
   logic               ovf_ff, ovf_in;

   logic               accept;
   logic               room;
   logic [CW-1:0]      count_nxt;
   logic               shift;

   srt_pkg::entry_type wave [N];     // wave[i] feeds cell i
   srt_pkg::entry_type held [N];
   srt_pkg::entry_type spill;        // out of the last cell, never valid
   logic [N-1:0]       wave_vld;

   // ---------------- control ----------------
   assign accept    = start && !busy;
   assign room      = (count_ff < CW'(N));
   assign count_nxt = count_ff + CW'(room);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srt_pkg::ST_LOAD: begin
            if (accept && req_item.last) state_in = srt_pkg::ST_SETTLE;
         end
         srt_pkg::ST_SETTLE: begin
            if (phase_ff == CW'(1)) state_in = srt_pkg::ST_DRAIN;
         end
         srt_pkg::ST_DRAIN: begin
            if (phase_ff == CW'(1)) state_in = srt_pkg::ST_LOAD;
         end
         default: state_in = srt_pkg::ST_LOAD;
      endcase
   end

   // outputs and counters
   always_comb begin
      count_in  = count_ff;
      phase_in  = phase_ff;
      ovf_in    = ovf_ff;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      shift     = 1'b0;
      unique case (state_ff)
         srt_pkg::ST_LOAD: begin
            busy = 1'b0;
            if (accept) begin
               count_in = count_nxt;
               if (!room) ovf_in = 1'b1;
               // load the settle countdown with the number of stored items
               if (req_item.last) phase_in = count_nxt;
            end
         end
         srt_pkg::ST_SETTLE: begin
            if (phase_ff == CW'(1)) phase_in = count_ff;
            else phase_in = phase_ff - CW'(1);
         end
         srt_pkg::ST_DRAIN: begin
            rsp_valid = 1'b1;
            shift     = 1'b1;
            phase_in  = phase_ff - CW'(1);
            if (phase_ff == CW'(1)) begin
               count_in = '0;
               ovf_in   = 1'b0;
            end
         end
         default: busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srt_pkg::ST_LOAD;
         count_ff <= '0;
         phase_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
         ovf_ff   <= ovf_in;
      end
   end

   // ---------------- sorting chain ----------------
   // A new item enters cell 0 directly; dropped items never enter.
   always_comb begin
      wave[0].vld   = accept && room;
      wave[0].value = req_item.value;
   end

   for (genvar i = 0; i < N; i++) begin : g_cell
      srt_pkg::entry_type right;
      srt_pkg::entry_type pass;

      if (i == N - 1) begin : g_end
         assign right = '0;
         assign spill = pass;
      end else begin : g_mid
         assign right       = held[i+1];
         assign wave[i+1]   = pass;
      end

      assign wave_vld[i] = wave[i].vld;

      srt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (shift),
         .wave_in  (wave[i]),
         .right_in (right),
         .held     (held[i]),
         .wave_out (pass)
      );
   end

   // cell 0 always holds the smallest remaining item while draining
   always_comb begin
      rsp_item.value_res  = held[0].value;
      rsp_item.last_res   = (phase_ff == CW'(1));
      rsp_item.overflowed = ovf_ff;
   end

   // ---------------- assertions ----------------
   a_no_spill: assert property (@(posedge clock) disable iff (reset)
      !spill.vld)
      else $error("element pushed off the end of the chain");

   a_drain_settled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (wave_vld == '0))
      else $error("insertion still in flight while draining");

   a_drain_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> held[0].vld)
      else $error("result taken from an empty cell");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.last_res) |=> (!rsp_valid && !busy && count_ff == '0))
      else $error("batch did not close after its final item");

endmodule

// ===== src/srt_cell.sv =====
// One cell of the systolic sorting chain: keeps the smaller element, passes the larger on.
// Depends on srt_pkg.
module srt_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  srt_pkg::entry_type wave_in,
   input  srt_pkg::entry_type right_in,
   output srt_pkg::entry_type held,
   output srt_pkg::entry_type wave_out
);

   srt_pkg::entry_type held_ff, held_in;
   srt_pkg::entry_type fwd_ff, fwd_in;

   always_comb begin
      held_in = held_ff;
      fwd_in  = '0;
      if (shift) begin
         held_in = right_in;
      end else if (wave_in.vld) begin
         if (!held_ff.vld) begin
            held_in = wave_in;
         end else if (wave_in.value < held_ff.value) begin
            held_in = wave_in;
            fwd_in  = held_ff;
         end else begin
            fwd_in = wave_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff.vld <= 1'b0;
         fwd_ff.vld  <= 1'b0;
      end else begin
         held_ff <= held_in;
         fwd_ff  <= fwd_in;
      end
   end

   assign held     = held_ff;
   assign wave_out = fwd_ff;

endmodule
